@@ sv/stbs_pkg.sv @@
// Package for the sorted table search block: word types, register codes, states.
`default_nettype none
package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int POS_W      = 11;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE    = 1'b1;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	localparam logic MODE_EXACT   = 1'b0;
	localparam logic MODE_NEAREST = 1'b1;

	typedef struct packed {
		logic               action;
		logic [9:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] search_key;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             hit;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP
	} state_t;

endpackage
`default_nettype wire

@@ sv/sorted_table_binary_search.sv @@
// Sorted table of signed words with exact and lower-bound binary search.
//
//  channel  | handshake          | word
//  ---------+--------------------+---------------------------------------
//  input    | start & !busy      | item   (action, index, value, key)
//  result   | done (one cycle)   | result (position, hit)
//  config   | cfg_we             | cfg_index, cfg_wdata
//
// A write word is stored when it is accepted and leaves busy low.
// A search makes one probe per halving of the span; each probe is a memory read
// (ST_PROBE) followed by a compare (ST_CMP).
// An empty table answers in the cycle after the search word, without raising busy.
// Reset clears the state, done and the config registers only; table contents stay undefined until written.
// The result cannot be stalled; a new word may start in the cycle done is high.
`default_nettype none
module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire item_t                 item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output      logic                  done,
	output      result_t               result
);

	localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW0 = $clog2(TABLE_DEPTH + 1);
	localparam int CW  = (CW0 > CFG_DATA_W) ? CW0 : CFG_DATA_W;
	localparam int XW  = (IW > 10) ? IW : 10;

	logic [CFG_DATA_W-1:0] entries_q;
	logic                  mode_q;

	state_t state_q, state_d;

	logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, count_q, count_d;
	logic               first_q, first_d, smode_q, smode_d;
	logic signed [31:0] key_q, key_d;
	logic               done_q;
	result_t            result_q;

	logic          fin;
	logic [CW-1:0] fin_pos;
	logic          rd_en;
	logic [CW-1:0] mid_c;
	logic [CW-1:0] cnt_ext, cnt_sat;
	logic          accept, wr_en;
	logic [XW-1:0] waddr;

	logic signed [31:0] table_mem [TABLE_DEPTH];
	logic signed [31:0] rd_s1;

	assign accept  = start && !busy;
	assign wr_en   = accept && (item.action == ACT_WRITE)
		&& (32'(item.entry_index) < 32'(TABLE_DEPTH));
	assign waddr   = XW'(item.entry_index);
	assign cnt_ext = CW'(entries_q);
	assign cnt_sat = (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;
	assign mid_c   = lo_q + ((hi_q - lo_q) >> 1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[waddr[IW-1:0]] <= item.entry_value;
		end
		if (rd_en) begin
			rd_s1 <= table_mem[mid_d[IW-1:0]];
		end
	end

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		count_d = count_q;
		first_d = first_q;
		smode_d = smode_q;
		key_d   = key_q;
		fin     = 1'b0;
		fin_pos = '0;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.action == ACT_SEARCH) begin
					key_d   = item.search_key;
					count_d = cnt_sat;
					smode_d = mode_q;
					first_d = 1'b1;
					lo_d    = '0;
					hi_d    = (mode_q == MODE_NEAREST) ? cnt_sat : cnt_sat - CW'(1);
					if (cnt_sat == '0) begin
						fin     = 1'b1;
						fin_pos = '0;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (smode_q == MODE_NEAREST) begin
					if (first_q) begin
						mid_d   = '0;
						rd_en   = 1'b1;
						state_d = ST_CMP;
					end else if (lo_q + CW'(1) < hi_q) begin
						mid_d   = mid_c;
						rd_en   = 1'b1;
						state_d = ST_CMP;
					end else begin
						fin     = 1'b1;
						fin_pos = hi_q;
						state_d = ST_IDLE;
					end
				end else begin
					if (lo_q <= hi_q) begin
						mid_d   = mid_c;
						rd_en   = 1'b1;
						state_d = ST_CMP;
					end else begin
						fin     = 1'b1;
						fin_pos = count_q;
						state_d = ST_IDLE;
					end
				end
			end
			ST_CMP: begin
				state_d = ST_PROBE;
				if (smode_q == MODE_NEAREST) begin
					if (first_q) begin
						if (rd_s1 >= key_q) begin
							fin     = 1'b1;
							fin_pos = '0;
							state_d = ST_IDLE;
						end
						first_d = 1'b0;
					end else if (rd_s1 < key_q) begin
						lo_d = mid_q;
					end else begin
						hi_d = mid_q;
					end
				end else begin
					if (rd_s1 < key_q) begin
						lo_d = mid_q + CW'(1);
					end else if (rd_s1 > key_q) begin
						if (mid_q == '0) begin
							fin     = 1'b1;
							fin_pos = count_q;
							state_d = ST_IDLE;
						end else begin
							hi_d = mid_q - CW'(1);
						end
					end else begin
						fin     = 1'b1;
						fin_pos = mid_q;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			entries_q <= '0;
			mode_q    <= MODE_EXACT;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				case (cfg_index)
					REG_ENTRIES_IN_USE: entries_q <= cfg_wdata;
					REG_SEARCH_MODE:    mode_q    <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		count_q <= count_d;
		first_q <= first_d;
		smode_q <= smode_d;
		key_q   <= key_d;
		if (fin) begin
			result_q.position <= POS_W'(fin_pos);
			result_q.hit      <= (fin_pos < count_d);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> $past(state_q == ST_PROBE))
		else $error("compare without a probe");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while a search runs");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.action == ACT_WRITE) |=> !busy && !done)
		else $error("write word started a search");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (CW'(result.position) < count_q || $past(state_q == ST_IDLE)))
		else $error("hit beyond entry count");

endmodule
`default_nettype wire

@@ tb/tb_sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_table_binary_search: exact and lower-bound searches checked against a predictor.
module tb_sorted_table_binary_search;
	import stbs_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int SEARCH_CYCLES = 24;
	localparam int QUIET_LIMIT = 2000;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint VMAX = 64'sd2147483647;

	class search_scoreboard;
		logic signed [31:0] tbl_mem [DEPTH];
		logic [10:0] entries;
		logic mode;
		result_t expected_q [$];
		int errors;

		function new();
			entries = '0;
			mode = MODE_EXACT;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_ENTRIES_IN_USE) begin
				entries = val;
			end else if (idx == REG_SEARCH_MODE) begin
				mode = val[0];
			end
		endfunction

		function int unsigned exact_lookup(int unsigned n, longint key);
			longint lo, hi, mid, v;
			if (n == 0) return 0;
			lo = 0;
			hi = longint'(n) - 1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				v = longint'(tbl_mem[mid]);
				if (v < key) begin
					lo = mid + 1;
				end else if (v > key) begin
					hi = mid - 1;
				end else begin
					return unsigned'(32'(mid));
				end
			end
			return n;
		endfunction

		function int unsigned lower_bound_lookup(int unsigned n, longint key);
			int unsigned lo, hi, mid;
			if (n == 0) return 0;
			if (longint'(tbl_mem[0]) >= key) return 0;
			lo = 0;
			hi = n;
			while (lo + 1 < hi) begin
				mid = lo + (hi - lo) / 2;
				if (longint'(tbl_mem[mid]) < key) begin
					lo = mid;
				end else begin
					hi = mid;
				end
			end
			return hi;
		endfunction

		function void note_item(item_t it);
			int unsigned n, pos;
			result_t r;
			if (it.action == ACT_WRITE) begin
				tbl_mem[it.entry_index] = it.entry_value;
				return;
			end
			n = (entries > DEPTH) ? DEPTH : entries;
			if (mode == MODE_NEAREST) begin
				pos = lower_bound_lookup(n, longint'($signed(it.search_key)));
			end else begin
				pos = exact_lookup(n, longint'($signed(it.search_key)));
			end
			r.position = pos[POS_W-1:0];
			r.hit = (pos < n);
			expected_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result position=%0d hit=%0d",
					$time, got.position, got.hit);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.position !== want.position) begin
				$display("%0t: position mismatch expected=%0d actual=%0d",
					$time, want.position, got.position);
				errors++;
			end
			if (got.hit !== want.hit) begin
				$display("%0t: hit mismatch expected=%0d actual=%0d",
					$time, want.hit, got.hit);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item_w;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic done;
	result_t result;

	search_scoreboard sb;
	bit idle_on;
	int quiet_cycles = 0;
	int directed_vals [8] = '{-2147483647, -1000, -1, 0, 0, 7, 12345, 2147483647};

	sorted_table_binary_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item_w),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.result   (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(result);
			if ((start && !busy) || done || cfg_we) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic longint rand_between(longint lo, longint hi);
		longint unsigned span;
		span = unsigned'(hi - lo);
		if (span >= 64'hFFFF_FFFF) return lo + longint'($urandom);
		return lo + longint'({$urandom, $urandom} % (span + 1));
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.action = 1'($urandom);
		it.entry_index = 10'($urandom);
		it.entry_value = $urandom;
		it.search_key = $urandom;
		return it;
	endfunction

	function automatic item_t make_write(int unsigned idx, logic signed [31:0] val);
		item_t it;
		it = noise_item();
		it.action = ACT_WRITE;
		it.entry_index = 10'(idx);
		it.entry_value = val;
		return it;
	endfunction

	function automatic item_t make_search(logic signed [31:0] key);
		item_t it;
		it = noise_item();
		it.action = ACT_SEARCH;
		it.search_key = key;
		return it;
	endfunction

	function automatic logic signed [31:0] pick_key(int unsigned n);
		int r;
		longint v;
		r = $urandom_range(0, 99);
		if (n > 0 && r < 50) return sb.tbl_mem[$urandom_range(0, n - 1)];
		if (n > 0 && r < 70) begin
			v = longint'(sb.tbl_mem[$urandom_range(0, n - 1)]);
			v = $urandom_range(0, 1) ? v + 1 : v - 1;
			return 32'(v);
		end
		if (r < 80) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return $urandom;
	endfunction

	// entered and left at a falling edge; start is left as driven
	task automatic send_item(input item_t it);
		if (idle_on && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			item_w <= noise_item();
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start <= 1'b1;
		item_w <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		while (busy) @(negedge clk);
		repeat (SEARCH_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [10:0] count, input logic m);
		settle();
		if ($urandom_range(0, 1)) begin
			set_reg(REG_ENTRIES_IN_USE, count);
			set_reg(REG_SEARCH_MODE, CFG_DATA_W'(m));
		end else begin
			set_reg(REG_SEARCH_MODE, CFG_DATA_W'(m));
			set_reg(REG_ENTRIES_IN_USE, count);
		end
	endtask

	// ascending run from index 0, spacing from all-duplicate to full range
	task automatic write_sorted(input int unsigned n);
		longint span, cur;
		int unsigned i;
		case ($urandom_range(0, 2))
			0: begin
				span = $urandom_range(0, 3);
			end
			1: begin
				span = $urandom_range(4, 5000);
			end
			default: begin
				span = ((64'sd1 <<< 32) - 64'sd1) / n;
			end
		endcase
		if (span > (64'sd1 <<< 31)) span = 64'sd1 <<< 31;
		cur = rand_between(VMIN, VMAX - longint'(n) * span);
		for (i = 0; i < n; i++) begin
			send_item(make_write(i, 32'(cur)));
			cur = cur + rand_between(0, span);
		end
	endtask

	initial begin
		int p, k, r;
		int unsigned n, idx;
		logic [10:0] count;
		logic m;
		longint lo, hi, val;

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		item_w = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table in both modes
		send_item(make_search(32'sd0));
		configure(11'd0, MODE_NEAREST);
		send_item(make_search(32'h8000_0000));

		for (k = 0; k < 8; k++) send_item(make_write(k, directed_vals[k]));

		configure(11'd8, MODE_EXACT);
		send_item(make_search(32'h7FFF_FFFF));
		send_item(make_search(32'h8000_0001));
		send_item(make_search(32'sd0));
		send_item(make_search(32'sd5));
		send_item(make_search(32'h8000_0000));
		// key below the first entry would take the upper bound under zero
		configure(11'd1, MODE_EXACT);
		send_item(make_search(32'h8000_0000));

		configure(11'd8, MODE_NEAREST);
		send_item(make_search(32'h8000_0000));
		send_item(make_search(32'sd0));
		send_item(make_search(32'sd8));
		send_item(make_search(32'h7FFF_FFFF));
		configure(11'd7, MODE_NEAREST);
		send_item(make_search(32'h7FFF_FFFF));
		// out-of-order entry
		send_item(make_write(2, 32'sd50000));
		send_item(make_search(32'sd1));

		settle();
		write_sorted(DEPTH);

		for (p = 0; p < 20; p++) begin
			idle_on = !(p >= 6 && p <= 9);
			r = $urandom_range(0, 99);
			if (p == 0) begin
				count = 11'd2047;
			end else if (p == 1) begin
				count = 11'(DEPTH);
			end else if (p == 2) begin
				count = 11'd0;
			end else if (r < 8) begin
				count = 11'd0;
			end else if (r < 16) begin
				count = 11'd1;
			end else if (r < 22) begin
				count = 11'd2;
			end else if (r < 30) begin
				count = 11'(DEPTH);
			end else if (r < 36) begin
				count = 11'($urandom_range(DEPTH + 1, 2047));
			end else if (r < 42) begin
				count = 11'd2047;
			end else if (r < 50) begin
				count = 11'($urandom_range(500, DEPTH - 1));
			end else begin
				count = 11'($urandom_range(3, 64));
			end
			m = (p == 1) ? MODE_NEAREST : 1'($urandom);
			configure(count, m);
			n = (count > DEPTH) ? DEPTH : count;
			if (n > 0 && n <= 64 && $urandom_range(0, 1)) write_sorted(n);

			for (k = 0; k < 6; k++) begin
				if ($urandom_range(0, 99) < 12) begin
					if (n > 0 && $urandom_range(0, 3) != 0) begin
						idx = $urandom_range(0, n - 1);
					end else begin
						idx = $urandom_range(0, DEPTH - 1);
					end
					lo = (idx > 0) ? longint'(sb.tbl_mem[idx - 1]) : VMIN;
					hi = (idx < DEPTH - 1) ? longint'(sb.tbl_mem[idx + 1]) : VMAX;
					if ($urandom_range(0, 3) != 0 && lo <= hi) begin
						val = rand_between(lo, hi);
					end else begin
						val = longint'($signed($urandom));
					end
					send_item(make_write(idx, 32'(val)));
				end else begin
					send_item(make_search(pick_key(n)));
				end
			end
		end

		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SEARCH_CYCLES + 6) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
